@@ hdl/pal_pkg.sv @@
// Package for the positional array list: sizes, operation and status codes,
// and the sequencer state type. No dependencies.
`timescale 1ns / 1ps

package pal_pkg;

  localparam int DEPTH  = 16;
  localparam int AW     = $clog2(DEPTH);
  localparam int CNT_W  = 5;
  localparam int POS_W  = 5;
  localparam int DATA_W = 32;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_DELETE = 2'd1,
    MODE_READ   = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_BADPOS = 2'd2,
    STAT_EMPTY  = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_WR,
    S_INS_PUT,
    S_FETCH_RD,
    S_FETCH_DATA,
    S_DEL_RD,
    S_DEL_WR,
    S_RESP
  } state_e;

endpackage

@@ hdl/pal_req_if.sv @@
// Request channel interface for the positional array list.
// Depends on pal_pkg for field widths.
`timescale 1ns / 1ps

interface pal_req_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       mode;
  logic [pal_pkg::POS_W-1:0]        position;
  logic signed [pal_pkg::DATA_W-1:0] value;

  modport source (output valid, output mode, output position, output value, input ready);
  modport sink   (input valid, input mode, input position, input value, output ready);
endinterface

@@ hdl/pal_rsp_if.sv @@
// Response channel interface for the positional array list.
// Depends on pal_pkg for field widths.
`timescale 1ns / 1ps

interface pal_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        status;
  logic signed [pal_pkg::DATA_W-1:0] data_out;
  logic [pal_pkg::CNT_W-1:0]         length;

  modport source (output valid, output status, output data_out, output length, input ready);
  modport sink   (input valid, input status, input data_out, input length, output ready);
endinterface

@@ hdl/positional_array_list.sv @@
// Top level of the positional array list: request checks, shift sequencer and
// response register. Depends on pal_pkg, pal_req_if, pal_rsp_if and pal_ram.
`timescale 1ns / 1ps
//
//  Channel | Direction | Fields                     | Handshake
//  --------+-----------+----------------------------+-----------
//  req_i   | in        | mode, position, value      | valid/ready
//  rsp_o   | out       | status, data_out, length   | valid/ready
//
// Every request gives exactly one response. A failed request or a clear goes
// straight on to the response, and a read first fetches the entry. An insert
// at position p first moves each entry from p onwards up by one place, and a
// delete moves each entry after p down by one place. Each move is a read of
// the entry RAM in one state and a write of that entry in the next state.
// Reset clears the length and the sequencer; the entry words need no clearing.
// Request ready is high only while the sequencer is idle, and a stalled
// response holds in its register until it is taken.

module positional_array_list (
  input  logic          clk_i,
  input  logic          rst_ni,
  pal_req_if.sink       req_i,
  pal_rsp_if.source     rsp_o
);

  localparam int AW    = pal_pkg::AW;
  localparam int CNT_W = pal_pkg::CNT_W;

  // Sequencer state and the length of the list are the only control state.
  pal_pkg::state_e  state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;

  // Latched request and the response being built.
  pal_pkg::mode_e                    mode_q, mode_d;
  logic [pal_pkg::POS_W-1:0]         pos_q, pos_d;
  logic [pal_pkg::DATA_W-1:0]        val_q, val_d;
  pal_pkg::status_e                  status_q, status_d;
  logic [pal_pkg::DATA_W-1:0]        dout_q, dout_d;

  // Shift index, stepped by the shared increment/decrement unit.
  logic [CNT_W-1:0] idx_q, idx_d;

  // Entry RAM port signals.
  logic                       ram_we;
  logic [AW-1:0]              ram_waddr;
  logic [pal_pkg::DATA_W-1:0] ram_wdata;
  logic [AW-1:0]              ram_raddr;
  logic [pal_pkg::DATA_W-1:0] ram_rdata;

  logic             accept;
  pal_pkg::mode_e   req_mode;
  pal_pkg::status_e chk_status;
  logic [CNT_W-1:0] count_inc;
  logic [CNT_W-1:0] pos_m1;
  logic             step_down;
  logic [CNT_W-1:0] idx_step;
  logic             ins_more;
  logic             del_more;

  assign req_mode = pal_pkg::mode_e'(req_i.mode);
  assign accept   = req_i.valid && req_i.ready;

  assign req_i.ready    = (state_q == pal_pkg::S_IDLE);
  assign rsp_o.valid    = (state_q == pal_pkg::S_RESP);
  assign rsp_o.status   = status_q;
  assign rsp_o.data_out = dout_q;
  assign rsp_o.length   = count_q;

  assign count_inc = count_q + CNT_W'(1);
  assign pos_m1    = pos_q - CNT_W'(1);

  // Request check. A full list is tested before the insert position, and an
  // empty list before the delete or read position.
  always_comb begin
    chk_status = pal_pkg::STAT_OK;
    case (req_mode)
      pal_pkg::MODE_INSERT: begin
        if (count_q >= CNT_W'(pal_pkg::DEPTH)) begin
          chk_status = pal_pkg::STAT_FULL;
        end else if (req_i.position == '0 || req_i.position > count_inc) begin
          chk_status = pal_pkg::STAT_BADPOS;
        end
      end
      pal_pkg::MODE_DELETE, pal_pkg::MODE_READ: begin
        if (count_q == '0) begin
          chk_status = pal_pkg::STAT_EMPTY;
        end else if (req_i.position == '0 || req_i.position > count_q) begin
          chk_status = pal_pkg::STAT_BADPOS;
        end
      end
      default: chk_status = pal_pkg::STAT_OK;
    endcase
  end

  // The shared index unit: one 5-bit adder that steps down while an insert
  // opens a gap and steps up while a delete closes one.
  assign step_down = (state_q == pal_pkg::S_INS_RD) || (state_q == pal_pkg::S_INS_WR);
  assign idx_step  = idx_q + (step_down ? {CNT_W{1'b1}} : CNT_W'(1));

  // An insert keeps moving entries up while the index has not reached the
  // target position; a delete keeps moving entries down while a later entry
  // is left.
  assign ins_more = (idx_q >= pos_q);
  assign del_more = (idx_step < count_q);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      pal_pkg::S_IDLE: begin
        if (accept) begin
          if (chk_status != pal_pkg::STAT_OK) begin
            state_d = pal_pkg::S_RESP;
          end else begin
            case (req_mode)
              pal_pkg::MODE_INSERT: state_d = pal_pkg::S_INS_RD;
              pal_pkg::MODE_DELETE,
              pal_pkg::MODE_READ:   state_d = pal_pkg::S_FETCH_RD;
              default:              state_d = pal_pkg::S_RESP;
            endcase
          end
        end
      end
      pal_pkg::S_INS_RD:     state_d = ins_more ? pal_pkg::S_INS_WR : pal_pkg::S_INS_PUT;
      pal_pkg::S_INS_WR:     state_d = pal_pkg::S_INS_RD;
      pal_pkg::S_INS_PUT:    state_d = pal_pkg::S_RESP;
      pal_pkg::S_FETCH_RD:   state_d = pal_pkg::S_FETCH_DATA;
      pal_pkg::S_FETCH_DATA: begin
        state_d = (mode_q == pal_pkg::MODE_DELETE) ? pal_pkg::S_DEL_RD : pal_pkg::S_RESP;
      end
      pal_pkg::S_DEL_RD:     state_d = del_more ? pal_pkg::S_DEL_WR : pal_pkg::S_RESP;
      pal_pkg::S_DEL_WR:     state_d = pal_pkg::S_DEL_RD;
      pal_pkg::S_RESP: begin
        if (rsp_o.ready) begin
          state_d = pal_pkg::S_IDLE;
        end
      end
      default: state_d = pal_pkg::S_IDLE;
    endcase
  end

  // Datapath and RAM controls for each state.
  always_comb begin
    count_d   = count_q;
    mode_d    = mode_q;
    pos_d     = pos_q;
    val_d     = val_q;
    status_d  = status_q;
    dout_d    = dout_q;
    idx_d     = idx_q;
    ram_we    = 1'b0;
    ram_waddr = idx_q[AW-1:0];
    ram_wdata = ram_rdata;
    ram_raddr = idx_step[AW-1:0];
    case (state_q)
      pal_pkg::S_IDLE: begin
        if (accept) begin
          mode_d   = req_mode;
          pos_d    = req_i.position;
          val_d    = req_i.value;
          status_d = chk_status;
          dout_d   = '0;
          idx_d    = count_q;
          if (chk_status == pal_pkg::STAT_OK && req_mode == pal_pkg::MODE_CLEAR) begin
            count_d = '0;
          end
        end
      end
      pal_pkg::S_INS_RD: begin
        // Fetch the entry just below the index.
        ram_raddr = idx_step[AW-1:0];
      end
      pal_pkg::S_INS_WR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q[AW-1:0];
        ram_wdata = ram_rdata;
        idx_d     = idx_step;
      end
      pal_pkg::S_INS_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = pos_m1[AW-1:0];
        ram_wdata = val_q;
        count_d   = count_inc;
      end
      pal_pkg::S_FETCH_RD: begin
        ram_raddr = pos_m1[AW-1:0];
      end
      pal_pkg::S_FETCH_DATA: begin
        dout_d = ram_rdata;
        idx_d  = pos_m1;
      end
      pal_pkg::S_DEL_RD: begin
        // Fetch the entry just above the index, or finish the delete.
        ram_raddr = idx_step[AW-1:0];
        if (!del_more) begin
          count_d = count_q - CNT_W'(1);
        end
      end
      pal_pkg::S_DEL_WR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q[AW-1:0];
        ram_wdata = ram_rdata;
        idx_d     = idx_step;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pal_pkg::S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q   <= mode_d;
    pos_q    <= pos_d;
    val_q    <= val_d;
    status_q <= status_d;
    dout_q   <= dout_d;
    idx_q    <= idx_d;
  end

  pal_ram #(
    .WIDTH (pal_pkg::DATA_W),
    .DEPTH (pal_pkg::DEPTH)
  ) u_entries (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

@@ hdl/pal_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module pal_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
